>>> rtl/isrs_pkg.sv
// Shared types, constants and codes for the integer root of square sums block.
package isrs_pkg;

   localparam int OPERAND_W = 32;
   localparam int ROOT_W    = 16;
   localparam int RAD_W     = 64;
   localparam int PROD_W    = 2 * OPERAND_W;
   localparam int REQ_W     = 104;
   localparam int RSP_W     = 16;

   localparam logic [ROOT_W-1:0] ROOT_LIMIT = 16'hB504;
   localparam logic [ROOT_W-1:0] ROOT_HALF  = ROOT_LIMIT >> 1;
   localparam logic [RAD_W-1:0]  LIMIT_SQ   = RAD_W'(ROOT_LIMIT) * RAD_W'(ROOT_LIMIT);

   localparam logic [1:0] OP_ROOT = 2'd0;
   localparam logic [1:0] OP_SUM  = 2'd1;
   localparam logic [1:0] OP_DIFF = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_A,
      ST_SQ_B,
      ST_SQ_C,
      ST_SUM,
      ST_RAD,
      ST_CHECK,
      ST_BIS_MUL,
      ST_BIS_CMP,
      ST_FINISH
   } isrs_state_type;

   typedef enum logic [1:0] {
      MUL_A,
      MUL_B,
      MUL_C,
      MUL_CUR
   } isrs_mul_sel_type;

   typedef struct packed {
      logic             ready;
      isrs_mul_sel_type mul_sel;
      logic             load_pos;
      logic             load_neg;
      logic             add_neg;
      logic             load_rad;
      logic             init_search;
      logic             step;
      logic             emit;
   } isrs_ctrl_type;

   typedef struct packed {
      logic req_valid;
      logic rad_zero;
      logic rad_sat;
      logic range_open;
      logic sq_hit;
      logic out_free;
   } isrs_status_type;

endpackage

>>> rtl/isrs_mul.sv
// Shared unsigned 32 by 32 multiplier with a registered product.
module isrs_mul
   import isrs_pkg::*;
(
   input  logic                 clock,
   input  logic [OPERAND_W-1:0] op_a,
   input  logic [OPERAND_W-1:0] op_b,
   output logic [PROD_W-1:0]    product
);

   logic [PROD_W-1:0] product_ff;
   logic [PROD_W-1:0] product_in;

   assign product_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

>>> rtl/isrs_ctrl.sv
// Sequencer that steps the shared multiplier through squaring and bisection.
module isrs_ctrl
   import isrs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  isrs_status_type status,
   output isrs_ctrl_type   ctrl,
   output isrs_state_type  state
);

   isrs_state_type state_ff;
   isrs_state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (status.req_valid) state_in = ST_SQ_A;
         end
         ST_SQ_A:  state_in = ST_SQ_B;
         ST_SQ_B:  state_in = ST_SQ_C;
         ST_SQ_C:  state_in = ST_SUM;
         ST_SUM:   state_in = ST_RAD;
         ST_RAD:   state_in = ST_CHECK;
         ST_CHECK: begin
            if (status.rad_zero || status.rad_sat) state_in = ST_FINISH;
            else state_in = ST_BIS_MUL;
         end
         ST_BIS_MUL: begin
            if (status.range_open) state_in = ST_BIS_CMP;
            else state_in = ST_FINISH;
         end
         ST_BIS_CMP: begin
            if (status.sq_hit) state_in = ST_FINISH;
            else state_in = ST_BIS_MUL;
         end
         ST_FINISH: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      ctrl.mul_sel = MUL_A;
      case (state_ff)
         ST_IDLE:    ctrl.ready = 1'b1;
         ST_SQ_A:    ctrl.mul_sel = MUL_A;
         ST_SQ_B: begin
            ctrl.mul_sel  = MUL_B;
            ctrl.load_pos = 1'b1;
         end
         ST_SQ_C: begin
            ctrl.mul_sel  = MUL_C;
            ctrl.load_neg = 1'b1;
         end
         ST_SUM:     ctrl.add_neg = 1'b1;
         ST_RAD:     ctrl.load_rad = 1'b1;
         ST_CHECK:   ctrl.init_search = 1'b1;
         ST_BIS_MUL: ctrl.mul_sel = MUL_CUR;
         ST_BIS_CMP: ctrl.step = 1'b1;
         ST_FINISH:  ctrl.emit = status.out_free;
         default:    ctrl.ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

endmodule

>>> rtl/integer_root_of_square_sums_core.sv
// Top level of the integer root of square sums block: operand path, bisection and output.
// Each request word carries an opcode and three signed 32-bit operands; the block
// answers with one response word holding the floor square root of a radicand picked by
// the opcode: the first operand itself (opcode 0, negative gives 0), the sum of the three
// squares (opcode 1), or the first square minus the other two (opcode 2, a negative
// difference gives 0); opcode 3 gives 0. Squares and sums are kept at full 64-bit width,
// so nothing wraps. Roots saturate at 46340. One 32 by 32 multiplier does all the work:
// it squares the three operand magnitudes in turn, then squares each bisection guess.
// The block takes one request word at a time. After acceptance it squares the three
// operand magnitudes and forms the radicand (states SQ_A, SQ_B, SQ_C, SUM and RAD), sets
// up the search, then runs bisection steps that each square the guess, then compare and
// narrow the interval, for at most sixteen steps plus one closing check, and hands the
// root to the output register. The search is skipped when the radicand is zero or
// saturates and stops early when a guess hits an exact square. The next request word is
// taken only once the sequencer is back in idle, after the root has been handed over. A
// finished root that finds the previous response word still in the output register waits
// until that word is taken. A finished response word waits in the output register while
// the next request word is accepted.
module integer_root_of_square_sums_core
   import isrs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // opcode [1:0], first_value [33:2], second_value [65:34], third_value [97:66], zeros above
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // root [15:0]
   output logic [RSP_W-1:0] rsp_tdata
);

   isrs_ctrl_type   ctrl;
   isrs_status_type status;
   isrs_state_type  state;

   // Captured request operands.
   logic [1:0]           opcode_ff;
   logic [OPERAND_W-1:0] a_ff, b_ff, c_ff;

   // Square accumulators and radicand.
   logic [RAD_W-1:0] pos_ff, neg_ff, rad_ff;
   logic [RAD_W-1:0] rad_in;

   // Bisection interval and current guess, which also holds the final root.
   logic [ROOT_W-1:0] low_ff, high_ff, cur_ff;
   logic [ROOT_W-1:0] low_in, high_in, cur_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [ROOT_W-1:0] rsp_root_ff;

   logic [OPERAND_W-1:0] mag_a, mag_b, mag_c;
   logic [OPERAND_W-1:0] mul_a;
   logic [PROD_W-1:0]    product;
   logic [RAD_W-1:0]     sum_w;
   logic [RAD_W:0]       diff_w;
   logic [ROOT_W:0]      mid_low, mid_high;
   logic                 sq_above;
   logic                 req_fire;

   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = ctrl.ready;

   // Magnitudes of the two's complement operands; the most negative value maps to 2^31.
   assign mag_a = a_ff[OPERAND_W-1] ? (~a_ff + 32'd1) : a_ff;
   assign mag_b = b_ff[OPERAND_W-1] ? (~b_ff + 32'd1) : b_ff;
   assign mag_c = c_ff[OPERAND_W-1] ? (~c_ff + 32'd1) : c_ff;

   always_comb begin
      case (ctrl.mul_sel)
         MUL_A:   mul_a = mag_a;
         MUL_B:   mul_a = mag_b;
         MUL_C:   mul_a = mag_c;
         MUL_CUR: mul_a = OPERAND_W'(cur_ff);
         default: mul_a = mag_a;
      endcase
   end

   isrs_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_a),
      .product (product)
   );

   isrs_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl),
      .state  (state)
   );

   // Radicand selection. The difference borrows when the negative part is larger,
   // and then the radicand is zero.
   assign sum_w  = pos_ff + neg_ff;
   assign diff_w = {1'b0, pos_ff} - {1'b0, neg_ff};

   always_comb begin
      case (opcode_ff)
         OP_ROOT: rad_in = a_ff[OPERAND_W-1] ? '0 : RAD_W'(a_ff);
         OP_SUM:  rad_in = sum_w;
         OP_DIFF: rad_in = diff_w[RAD_W] ? '0 : diff_w[RAD_W-1:0];
         default: rad_in = '0;
      endcase
   end

   // Both possible next guesses are formed ahead of the compare.
   assign mid_low  = ({1'b0, cur_ff} + {1'b0, low_ff}) >> 1;
   assign mid_high = ({1'b0, high_ff} + {1'b0, cur_ff}) >> 1;
   assign sq_above = product > rad_ff;

   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      cur_in  = cur_ff;
      if (ctrl.init_search) begin
         low_in  = '0;
         high_in = ROOT_LIMIT;
         if (status.rad_zero) cur_in = '0;
         else if (status.rad_sat) cur_in = ROOT_LIMIT;
         else cur_in = ROOT_HALF;
      end else if (ctrl.step && !status.sq_hit) begin
         if (sq_above) begin
            high_in = cur_ff;
            cur_in  = mid_low[ROOT_W-1:0];
         end else begin
            low_in = cur_ff;
            cur_in = mid_high[ROOT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         opcode_ff <= req_tdata[1:0];
         a_ff      <= req_tdata[33:2];
         b_ff      <= req_tdata[65:34];
         c_ff      <= req_tdata[97:66];
      end
      if (ctrl.load_pos) pos_ff <= product;
      if (ctrl.load_neg) neg_ff <= product;
      if (ctrl.add_neg)  neg_ff <= neg_ff + product;
      if (ctrl.load_rad) rad_ff <= rad_in;
      low_ff  <= low_in;
      high_ff <= high_in;
      cur_ff  <= cur_in;
      if (ctrl.emit) rsp_root_ff <= cur_ff;
   end

   assign status.req_valid  = req_tvalid;
   assign status.rad_zero   = (rad_ff == '0);
   assign status.rad_sat    = (rad_ff >= LIMIT_SQ);
   assign status.range_open = {1'b0, high_ff} > ({1'b0, low_ff} + 17'd1);
   assign status.sq_hit     = (product == rad_ff);
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.emit) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_root_ff;

`ifndef ASSERT_OFF
   // An accepted request word always starts the squaring sequence.
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state == ST_SQ_A)
      else $error("accepted request did not start squaring");

   // While the interval is still open the guess lies strictly inside it.
   assert property (@(posedge clock) disable iff (reset)
      (state == ST_BIS_MUL && status.range_open) |-> (low_ff < cur_ff && cur_ff < high_ff))
      else $error("bisection guess left its interval");

   // A response word appears only after the sequencer finished an item.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state == ST_FINISH))
      else $error("response raised outside the finish step");

   // Roots never exceed the saturation limit.
   assert property (@(posedge clock) disable iff (reset)
      ctrl.emit |-> cur_ff <= ROOT_LIMIT)
      else $error("root above saturation limit");
`endif

endmodule

>>> verif/integer_root_of_square_sums_core_test.sv
// Self-checking testbench for the integer root of square sums core.
module integer_root_of_square_sums_core_test
   import isrs_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // Opcode 3 has no name in the package; the block must answer it with a zero root.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // Generous bound on the whole run, which covers about 1700 words plus sender gaps,
   // receiver stalls and the long hold-off.
   localparam int CYCLE_LIMIT   = 1_000_000;
   // Wait at the end for longer than the longest bisection.
   localparam int SETTLE_CYCLES = 64;
   // Length of the receiver hold-off that makes the block back up into its input.
   localparam int HOLD_OFF_CYCLES = 500;
   localparam int PHASE_WORDS    = 410;
   localparam int PRESSURE_WORDS = 40;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   // Keeps the roots still owed by the block, oldest first, and checks each response
   // word against the oldest one.
   class root_scoreboard;
      logic [ROOT_W-1:0] owed_roots[$];
      int                mismatches;

      function new();
         mismatches = 0;
      endfunction

      function logic [RAD_W-1:0] square_of(logic [OPERAND_W-1:0] value);
         logic [OPERAND_W-1:0] magnitude;
         magnitude = value[OPERAND_W-1] ? -value : value;
         return RAD_W'(magnitude) * RAD_W'(magnitude);
      endfunction

      // Bisection over 0 to the root limit, stopping early on an exact square.
      function logic [ROOT_W-1:0] floor_root(logic [RAD_W-1:0] radicand);
         logic [RAD_W-1:0] upper;
         logic [RAD_W-1:0] lower;
         logic [RAD_W-1:0] guess;
         logic [RAD_W-1:0] guess_sq;
         if (radicand == 0) begin
            return '0;
         end
         if (radicand >= LIMIT_SQ) begin
            return ROOT_LIMIT;
         end
         upper = RAD_W'(ROOT_LIMIT);
         lower = '0;
         guess = RAD_W'(ROOT_HALF);
         while (upper > lower + 1) begin
            guess_sq = guess * guess;
            if (guess_sq == radicand) begin
               return guess[ROOT_W-1:0];
            end
            if (guess_sq > radicand) begin
               upper = guess;
            end else begin
               lower = guess;
            end
            guess = (upper + lower) >> 1;
         end
         return guess[ROOT_W-1:0];
      endfunction

      function void note_request(logic [1:0] opcode, logic [OPERAND_W-1:0] first,
                                 logic [OPERAND_W-1:0] second,
                                 logic [OPERAND_W-1:0] third);
         logic [RAD_W-1:0] radicand;
         logic [RAD_W-1:0] positive;
         logic [RAD_W-1:0] negative;
         radicand = '0;
         case (opcode)
            OP_ROOT: begin
               radicand = first[OPERAND_W-1] ? '0 : RAD_W'(first);
            end
            OP_SUM: begin
               radicand = square_of(first) + square_of(second) + square_of(third);
            end
            OP_DIFF: begin
               positive = square_of(first);
               negative = square_of(second) + square_of(third);
               radicand = (positive > negative) ? positive - negative : '0;
            end
            default: begin
               radicand = '0;
            end
         endcase
         owed_roots.push_back(floor_root(radicand));
      endfunction

      function void check_root(logic [ROOT_W-1:0] actual);
         logic [ROOT_W-1:0] expected;
         if (owed_roots.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("ERROR: unexpected response word, root %0d", actual);
            end
            return;
         end
         expected = owed_roots.pop_front();
         if (actual !== expected) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("ERROR: root mismatch, expected %0d, actual %0d", expected, actual);
            end
         end
      endfunction

      function int pending();
         return owed_roots.size();
      endfunction
   endclass

   // All block inputs start at known values; reset is held from time zero.
   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   root_scoreboard   board;
   idle_mode_type    idle_mode = IDLE_NONE;
   bit               hold_off_requested = 1'b0;
   bit               hold_off_taken = 1'b0;
   int               hold_off_left = 0;
   int               cycle_count = 0;

   integer_root_of_square_sums_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog: a stuck handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("integer_root_of_square_sums_core_test NOT OK");
         $finish;
      end
   end

   // Receiver side. Each edge first checks a word that was handed over at this edge,
   // using the values from just before the edge, then picks the ready level for the
   // next cycle. The long hold-off is counted here, once the main sequence asks for it.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            board.check_root(rsp_tdata);
         end
         if (hold_off_requested && !hold_off_taken) begin
            hold_off_taken = 1'b1;
            hold_off_left = HOLD_OFF_CYCLES;
         end
      end
      if (hold_off_left > 0) begin
         hold_off_left = hold_off_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         case (idle_mode)
            IDLE_RECEIVER: rsp_tready <= ($urandom_range(99) >= 83);
            IDLE_BOTH:     rsp_tready <= ($urandom_range(99) >= 17);
            default:       rsp_tready <= 1'b1;
         endcase
      end
   end

   function automatic bit sender_idles();
      case (idle_mode)
         IDLE_SENDER: return $urandom_range(99) < 83;
         IDLE_BOTH:   return $urandom_range(99) < 17;
         default:     return 1'b0;
      endcase
   endfunction

   // Offers one request word and returns at the edge where it is taken. Valid is only
   // lowered during an idle gap, so back-to-back words keep it high without a glitch.
   task automatic send_word(logic [1:0] opcode, logic [OPERAND_W-1:0] first,
                            logic [OPERAND_W-1:0] second, logic [OPERAND_W-1:0] third);
      while (sender_idles()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, third, second, first, opcode};
      do begin
         @(posedge clock);
      end while (!req_tready);
      board.note_request(opcode, first, second, third);
   endtask

   // Stops offering words and waits until every owed root has come back.
   task automatic wait_for_roots();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   // Operands drawn from several shapes: small values, full-range values, values
   // scaled down by a random shift, values right around the root limit, and extremes.
   function automatic logic [OPERAND_W-1:0] random_operand();
      logic [OPERAND_W-1:0] value;
      case ($urandom_range(4))
         0: value = $urandom_range(4000) - 2000;
         1: value = $urandom;
         2: begin
            value = $urandom >> $urandom_range(31);
            if ($urandom_range(1)) begin
               value = -value;
            end
         end
         3: begin
            value = 32'd46340 + $urandom_range(8) - 4;
            if ($urandom_range(1)) begin
               value = -value;
            end
         end
         default: begin
            case ($urandom_range(4))
               0: value = 32'h0000_0000;
               1: value = 32'h0000_0001;
               2: value = 32'hFFFF_FFFF;
               3: value = 32'h7FFF_FFFF;
               default: value = 32'h8000_0000;
            endcase
         end
      endcase
      return value;
   endfunction

   task automatic send_random_word();
      logic [1:0]           opcode;
      logic [OPERAND_W-1:0] first;
      logic [OPERAND_W-1:0] second;
      logic [OPERAND_W-1:0] third;
      logic [OPERAND_W-1:0] base;
      opcode = ($urandom_range(99) < 5) ? OP_UNUSED : 2'($urandom_range(2));
      first  = random_operand();
      second = random_operand();
      third  = random_operand();
      if (opcode == OP_ROOT && $urandom_range(3) == 0) begin
         // Exact squares and their neighbors exercise the early stop and the floor.
         base  = $urandom_range(46340);
         first = base * base + $urandom_range(2) - 1;
      end else if (opcode == OP_DIFF && $urandom_range(1)) begin
         // Keep the subtracted squares smaller so most differences stay positive.
         second = second >>> $urandom_range(31, 8);
         third  = third >>> $urandom_range(31, 8);
      end
      send_word(opcode, first, second, third);
   endtask

   task automatic run_phase(idle_mode_type mode, int words);
      idle_mode <= mode;
      repeat (words) begin
         send_random_word();
      end
      wait_for_roots();
   endtask

   initial begin
      board = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words: root of the first operand.
      send_word(OP_ROOT, 32'd0, 32'd0, 32'd0);
      send_word(OP_ROOT, 32'd1, 32'hFFFF_FFFF, 32'h8000_0000);
      send_word(OP_ROOT, 32'd2, 32'd0, 32'd0);
      send_word(OP_ROOT, 32'd4, 32'd0, 32'd0);
      send_word(OP_ROOT, 32'd1073741824, 32'd0, 32'd0);
      send_word(OP_ROOT, 32'd2147302921, 32'd0, 32'd0);
      send_word(OP_ROOT, 32'd2147395599, 32'd0, 32'd0);
      send_word(OP_ROOT, 32'd2147395600, 32'd0, 32'd0);
      send_word(OP_ROOT, 32'h7FFF_FFFF, 32'd0, 32'd0);
      send_word(OP_ROOT, 32'hFFFF_FFFF, 32'd0, 32'd0);
      send_word(OP_ROOT, 32'h8000_0000, 32'd0, 32'd0);
      // Sum of three squares.
      send_word(OP_SUM, 32'd0, 32'd0, 32'd0);
      send_word(OP_SUM, 32'd3, 32'hFFFF_FFFC, 32'd0);
      send_word(OP_SUM, 32'd1, 32'd1, 32'd1);
      send_word(OP_SUM, 32'd0, 32'd0, -32'sd46339);
      send_word(OP_SUM, 32'd100, -32'sd200, 32'd300);
      send_word(OP_SUM, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      // First square minus the others: positive, negative, equal and saturating.
      send_word(OP_DIFF, 32'd5, 32'd3, 32'd0);
      send_word(OP_DIFF, 32'd3, 32'd4, 32'd0);
      send_word(OP_DIFF, 32'd7, 32'hFFFF_FFF9, 32'd0);
      send_word(OP_DIFF, 32'd1000, 32'd0, 32'd1);
      send_word(OP_DIFF, 32'd46341, 32'd1, 32'd1);
      send_word(OP_DIFF, 32'h8000_0000, 32'h8000_0001, 32'd0);
      send_word(OP_DIFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      // The unused opcode always answers zero.
      send_word(OP_UNUSED, 32'h7FFF_FFFF, 32'd5, 32'd5);
      wait_for_roots();

      run_phase(IDLE_NONE, PHASE_WORDS);
      run_phase(IDLE_SENDER, PHASE_WORDS);
      run_phase(IDLE_RECEIVER, PHASE_WORDS);
      run_phase(IDLE_BOTH, PHASE_WORDS);

      // Hold the receiver off while words keep coming, so the block backs up and
      // stalls its input, then let it drain.
      idle_mode <= IDLE_NONE;
      hold_off_requested = 1'b1;
      repeat (PRESSURE_WORDS) begin
         send_random_word();
      end
      wait_for_roots();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("integer_root_of_square_sums_core_test OK");
      end else begin
         $display("integer_root_of_square_sums_core_test NOT OK");
      end
      $finish;
   end

endmodule
